>>> hw/rtl/mer_pkg.sv
// Shared types for the midpoint ellipse rasterizer.
// Holds the controller state, datapath opcodes and the status group.
// No dependencies.
package mer_pkg;

  typedef enum logic [3:0] {
    ST_READY,
    ST_SQ_X,
    ST_SQ_Y,
    ST_RX2_RY,
    ST_START_DEC,
    ST_STEP,
    ST_R2_M1,
    ST_R2_M2,
    ST_R2_M3,
    ST_R2_M4,
    ST_R2_M5,
    ST_R2_M6,
    ST_DEC,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_X,
    OP_SQ_Y,
    OP_RX2_RY,
    OP_START_DEC,
    OP_STEP,
    OP_R2_M1,
    OP_R2_M2,
    OP_R2_M3,
    OP_R2_M4,
    OP_R2_M5,
    OP_R2_M6,
    OP_DEC,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    K_R1_NEG,
    K_R1_POS,
    K_R2_POS,
    K_R2_NEG
  } step_kind_t;

  typedef struct packed {
    logic busy;
    logic region_one;
    logic in_region_two;
    logic y_zero;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/mer_ctrl.sv
// Controller of the midpoint ellipse rasterizer.
// Sequences datapath opcodes per item; depends on mer_pkg.
module mer_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             s_tuser,
  input  mer_pkg::status_t status,
  output mer_pkg::dp_op_t  op
);
  import mer_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = OP_NONE;
    s_tready = 1'b0;
    unique case (state)
      ST_READY: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (!s_tuser) begin
            op = OP_LOAD;
            state_next = ST_SQ_X;
          end else if (status.busy) begin
            state_next = ST_STEP;
          end
        end
      end
      ST_SQ_X: begin
        op = OP_SQ_X;
        state_next = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        op = OP_SQ_Y;
        state_next = ST_RX2_RY;
      end
      ST_RX2_RY: begin
        op = OP_RX2_RY;
        state_next = ST_START_DEC;
      end
      ST_START_DEC: begin
        op = OP_START_DEC;
        state_next = ST_READY;
      end
      ST_STEP: begin
        op = OP_STEP;
        priority if (status.region_one) begin
          state_next = ST_DEC;
        end else if (!status.in_region_two) begin
          state_next = ST_R2_M1;
        end else if (status.y_zero) begin
          state_next = ST_READY;
        end else begin
          state_next = ST_DEC;
        end
      end
      ST_R2_M1: begin
        op = OP_R2_M1;
        state_next = ST_R2_M2;
      end
      ST_R2_M2: begin
        op = OP_R2_M2;
        state_next = ST_R2_M3;
      end
      ST_R2_M3: begin
        op = OP_R2_M3;
        state_next = ST_R2_M4;
      end
      ST_R2_M4: begin
        op = OP_R2_M4;
        state_next = ST_R2_M5;
      end
      ST_R2_M5: begin
        op = OP_R2_M5;
        state_next = ST_R2_M6;
      end
      ST_R2_M6: begin
        op = OP_R2_M6;
        state_next = ST_STEP;
      end
      ST_DEC: begin
        op = OP_DEC;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          op = OP_EMIT;
          state_next = ST_READY;
        end
      end
      default: begin
        state_next = ST_READY;
      end
    endcase
  end

endmodule

>>> hw/rtl/mer_datapath.sv
// Datapath of the midpoint ellipse rasterizer: geometry, tracked products,
// decision variable, shared multiplier and output register. Uses mer_pkg.
module mer_datapath #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 11,
  parameter int IN_W        = 48,
  parameter int OUT_W       = 56
) (
  input  logic             clk,
  input  logic             rst,
  input  mer_pkg::dp_op_t  op,
  output mer_pkg::status_t status,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);
  import mer_pkg::*;

  localparam int R  = RADIUS_BITS;
  localparam int C  = COORD_BITS;
  localparam int SQ = 2 * R;
  localparam int TW = 3 * R;
  localparam int DW = 4 * R + 8;
  localparam int OW = ((C > R) ? C : R) + 2;
  localparam int MA = 3 * R + 2;
  localparam int MB = 2 * R + 1;
  localparam int MP = MA + MB;

  logic [R-1:0]           semi_x, semi_y, offset_x, offset_y;
  logic [C-1:0]           origin_col, origin_row;
  logic [SQ-1:0]          rx2, ry2;
  logic [TW-1:0]          tx, ty;
  logic signed [DW-1:0]   decision, prod, acc;
  logic                   in_region_two, busy;
  step_kind_t             kind;
  logic [OW-1:0]          right_column, left_column, lower_row, upper_row;

  logic signed [MA-1:0]   mul_a;
  logic signed [MB-1:0]   mul_b;
  logic signed [MP-1:0]   product;
  logic [R:0]             x_odd;
  logic signed [R:0]      y_m1;
  logic signed [DW-1:0]   rx2_ext, ry2_ext, tx8, ty8, term_x8, term_y8, term_c;
  logic signed [DW-1:0]   dec_sum, start_dec;
  logic                   region_one, dec_neg, dec_pos, y_zero, out_free;

  assign x_odd = {offset_x, 1'b1};
  assign y_m1  = $signed({1'b0, offset_y}) - $signed((R+1)'(1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      OP_SQ_X: begin
        mul_a = $signed({{(MA-R){1'b0}}, semi_x});
        mul_b = $signed({{(MB-R){1'b0}}, semi_x});
      end
      OP_SQ_Y: begin
        mul_a = $signed({{(MA-R){1'b0}}, semi_y});
        mul_b = $signed({{(MB-R){1'b0}}, semi_y});
      end
      OP_RX2_RY: begin
        mul_a = $signed({{(MA-SQ){1'b0}}, rx2});
        mul_b = $signed({{(MB-R){1'b0}}, semi_y});
      end
      OP_R2_M1: begin
        mul_a = $signed({{(MA-SQ){1'b0}}, ry2});
        mul_b = $signed({{(MB-R-1){1'b0}}, x_odd});
      end
      OP_R2_M2: begin
        mul_a = prod[MA-1:0];
        mul_b = $signed({{(MB-R-1){1'b0}}, x_odd});
      end
      OP_R2_M3: begin
        mul_a = $signed({{(MA-SQ){1'b0}}, rx2});
        mul_b = $signed({{(MB-R-1){y_m1[R]}}, y_m1});
      end
      OP_R2_M4: begin
        mul_a = prod[MA-1:0];
        mul_b = $signed({{(MB-R-1){y_m1[R]}}, y_m1});
      end
      OP_R2_M5: begin
        mul_a = $signed({{(MA-SQ){1'b0}}, rx2});
        mul_b = $signed({{(MB-SQ){1'b0}}, ry2});
      end
      default: begin
      end
    endcase
  end

  assign product = mul_a * mul_b;

  assign rx2_ext = $signed({{(DW-SQ){1'b0}}, rx2});
  assign ry2_ext = $signed({{(DW-SQ){1'b0}}, ry2});
  assign tx8     = $signed({{(DW-TW-3){1'b0}}, tx, 3'b000});
  assign ty8     = $signed({{(DW-TW-3){1'b0}}, ty, 3'b000});
  assign term_x8 = (kind != K_R2_POS) ? tx8 : '0;
  assign term_y8 = (kind != K_R1_NEG) ? ty8 : '0;
  assign term_c  = (kind == K_R1_NEG || kind == K_R1_POS) ? (ry2_ext <<< 2) : (rx2_ext <<< 2);
  assign dec_sum = decision + term_x8 - term_y8 + term_c;
  // first decision, scaled by four: 4ry^2 + rx^2 - 4rx^2*ry
  assign start_dec = (ry2_ext <<< 2) + rx2_ext - (prod <<< 2);

  assign region_one = !in_region_two && (tx <= ty);
  assign dec_neg    = decision[DW-1];
  assign dec_pos    = !decision[DW-1] && (decision != '0);
  assign y_zero     = (offset_y == '0);
  assign out_free   = !m_tvalid || m_tready;

  assign status.busy          = busy;
  assign status.region_one    = region_one;
  assign status.in_region_two = in_region_two;
  assign status.y_zero        = y_zero;
  assign status.out_free      = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      in_region_two <= 1'b0;
    end else begin
      unique case (op)
        OP_LOAD: begin
          semi_x <= s_tdata[R-1:0];
          semi_y <= s_tdata[2*R-1:R];
          origin_col <= s_tdata[2*R+C-1:2*R];
          origin_row <= s_tdata[2*R+2*C-1:2*R+C];
          offset_x <= '0;
          offset_y <= s_tdata[2*R-1:R];
          in_region_two <= 1'b0;
        end
        OP_SQ_X: begin
          prod <= DW'(product);
        end
        OP_SQ_Y: begin
          rx2 <= prod[SQ-1:0];
          prod <= DW'(product);
        end
        OP_RX2_RY: begin
          ry2 <= prod[SQ-1:0];
          prod <= DW'(product);
        end
        OP_START_DEC: begin
          decision <= start_dec;
          ty <= prod[TW-1:0];
          tx <= '0;
          busy <= (semi_y != '0);
        end
        OP_STEP: begin
          if (region_one) begin
            offset_x <= offset_x + 1'b1;
            tx <= tx + TW'(ry2);
            if (dec_neg) begin
              kind <= K_R1_NEG;
            end else begin
              kind <= K_R1_POS;
              if (!y_zero) begin
                offset_y <= offset_y - 1'b1;
                ty <= ty - TW'(rx2);
              end
            end
          end else if (in_region_two) begin
            if (y_zero) begin
              busy <= 1'b0;
            end else begin
              offset_y <= offset_y - 1'b1;
              ty <= ty - TW'(rx2);
              if (dec_pos) begin
                kind <= K_R2_POS;
              end else begin
                kind <= K_R2_NEG;
                offset_x <= offset_x + 1'b1;
                tx <= tx + TW'(ry2);
              end
            end
          end
        end
        OP_R2_M1, OP_R2_M2, OP_R2_M4: begin
          prod <= DW'(product);
        end
        OP_R2_M3: begin
          acc <= prod;
          prod <= DW'(product);
        end
        OP_R2_M5: begin
          acc <= acc + (prod <<< 2);
          prod <= DW'(product);
        end
        OP_R2_M6: begin
          decision <= acc - (prod <<< 2);
          in_region_two <= 1'b1;
        end
        OP_DEC: begin
          decision <= dec_sum;
        end
        OP_EMIT: begin
          if (y_zero) begin
            busy <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op == OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      right_column <= {{(OW-C){1'b0}}, origin_col} + {{(OW-R){1'b0}}, offset_x};
      left_column  <= {{(OW-C){1'b0}}, origin_col} - {{(OW-R){1'b0}}, offset_x};
      lower_row    <= {{(OW-C){1'b0}}, origin_row} + {{(OW-R){1'b0}}, offset_y};
      upper_row    <= {{(OW-C){1'b0}}, origin_row} - {{(OW-R){1'b0}}, offset_y};
      m_tlast      <= y_zero;
    end
  end

  assign m_tdata = OUT_W'({upper_row, lower_row, left_column, right_column});

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT && y_zero) |=> (!busy && m_tvalid))
    else $error("last point did not end the ellipse");

  a_r2_end: assert property (@(posedge clk) disable iff (rst)
    (op == OP_STEP && in_region_two && y_zero) |=> !busy)
    else $error("region two end left block busy");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(op) == OP_EMIT))
    else $error("output valid without emit");

  a_r2_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(in_region_two) |-> ($past(op) == OP_R2_M6))
    else $error("region two entered without its setup");

endmodule

>>> hw/rtl/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer.
// Instantiates mer_ctrl and mer_datapath; uses mer_pkg.
//
// Usage: items arrive on the s_ channel. s_tuser = 0 starts an ellipse with
// the radii and center in s_tdata and gives no output; s_tuser = 1 advances
// one point and gives one item on the m_ channel with the four mirrored
// coordinates, m_tlast high on the point where y reaches zero. Advances
// while no ellipse is running are accepted and dropped.
// A start runs three multiplies on one shared multiplier. A point goes
// through a step state and a decision state before its output step loads
// the output register; the first region-two point first runs six setup
// steps (five multiplies) and a second step. One item is worked on at a
// time. Reset clears the controller, the running flag and the output valid.
// When the receiver stalls, the result waits in the output register; the
// next item is still accepted and is held before its output step until
// the register frees.
module midpoint_ellipse_rasterizer #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 11
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // radius_x, radius_y, center_x, center_y, zero pad
  input  logic [((2*RADIUS_BITS+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // command
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // right_column, left_column, lower_row, upper_row, zero pad
  output logic [((4*(((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)+2)+7)/8)*8-1:0]
    m_tdata,
  output logic m_tlast
);
  import mer_pkg::*;

  localparam int IN_W  = ((2*RADIUS_BITS+2*COORD_BITS+7)/8)*8;
  localparam int OUT_W =
    ((4*(((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)+2)+7)/8)*8;

  dp_op_t  op;
  status_t status;

  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .op       (op)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> bench/tb_top.sv
// Testbench for midpoint_ellipse_rasterizer: directed table, then random ellipses.
// Takes points from its two-region midpoint tracer or the table; checks m_ items in order.
// Depends on mer_pkg and the RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mer_pkg::*;

  localparam int IN_W        = ((2 * 10 + 2 * 11 + 7) / 8) * 8;
  localparam int OUT_W       = ((4 * 13 + 7) / 8) * 8;
  localparam int RAND_ITEMS  = 1700;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int NDIR        = 24;

  localparam bit CMD_START   = 1'b0;
  localparam bit CMD_ADVANCE = 1'b1;

  typedef enum bit [1:0] {
    ROW_PRED,
    ROW_NONE,
    ROW_POINT
  } row_check_t;

  typedef struct packed {
    bit         cmd;
    int         rx;
    int         ry;
    int         cx;
    int         cy;
    row_check_t chk;
    int         rc;
    int         lc;
    int         lr;
    int         ur;
    bit         lst;
  } stim_row_t;

  typedef struct packed {
    logic [12:0] right_col;
    logic [12:0] left_col;
    logic [12:0] lower_row;
    logic [12:0] upper_row;
    logic        last;
  } pixel_t;

  localparam stim_row_t DIR_TAB [NDIR] = '{
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_NONE,     0,  0,    0,     0, 1'b0},
    '{CMD_START,   1023, 1023,    0,    0, ROW_NONE,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_POINT,    1, -1, 1023, -1023, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_PRED,     0,  0,    0,     0, 1'b0},
    // restart while the previous ellipse is still running
    '{CMD_START,   1023, 1023, 2047, 2047, ROW_NONE,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_POINT, 2048, 2046, 3070, 1024, 1'b0},
    '{CMD_START,      1,    1,    0,    0, ROW_NONE,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_POINT,    1, -1,    0,     0, 1'b1},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_NONE,     0,  0,    0,     0, 1'b0},
    // zero horizontal radius: vertical run at x=1
    '{CMD_START,      0,    2,    5,    5, ROW_NONE,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_POINT,    6,  4,    6,     4, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_POINT,    6,  4,    5,     5, 1'b1},
    // zero vertical radius: nothing to draw
    '{CMD_START,      5,    0,  100,  100, ROW_NONE,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_NONE,     0,  0,    0,     0, 1'b0},
    '{CMD_START,      3,    2, 1024, 1024, ROW_PRED,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_PRED,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_PRED,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_PRED,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_PRED,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_PRED,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_PRED,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_PRED,     0,  0,    0,     0, 1'b0},
    '{CMD_ADVANCE,    0,    0,    0,    0, ROW_PRED,     0,  0,    0,     0, 1'b0},
    '{CMD_START,      2,    7,  300, 1500, ROW_PRED,     0,  0,    0,     0, 1'b0}
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;   // radius_x, radius_y, center_x, center_y, zero pad
  logic             s_tuser;   // command
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;   // right_column, left_column, lower_row, upper_row, zero pad
  logic             m_tlast;   // last_point

  midpoint_ellipse_rasterizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // tracer state
  longint     semi_x, semi_y, orig_col, orig_row, off_x, off_y, dec4;
  bit         region_two;
  bit         running;

  pixel_t     pending_pixels [$];
  int         src_idle_pct;
  int         sink_idle_pct;
  bit         hold_req;
  int         fail_count;
  int         items_done;
  int         items_ignored;
  int         points_checked;
  int         ellipses_closed;
  int         ellipses_started;
  int         kind_seen [4];
  int         stall_cycles;

  function automatic bit step_arc(input bit cmd, input int rx, input int ry, input int cx,
                                  input int cy, output pixel_t px, output step_kind_t kind);
    longint rx2, ry2, hx, hy;
    px = '0;
    kind = K_R1_NEG;
    if (cmd == CMD_START) begin
      semi_x = rx;
      semi_y = ry;
      orig_col = cx;
      orig_row = cy;
      off_x = 0;
      off_y = ry;
      rx2 = semi_x * semi_x;
      ry2 = semi_y * semi_y;
      dec4 = 4 * ry2 + rx2 - 4 * rx2 * semi_y;
      region_two = 1'b0;
      running = (ry != 0);
      return 1'b0;
    end
    if (!running) return 1'b0;
    rx2 = semi_x * semi_x;
    ry2 = semi_y * semi_y;
    if (!region_two && ry2 * off_x <= rx2 * off_y) begin
      if (dec4 < 0) begin
        kind = K_R1_NEG;
        off_x++;
        dec4 += 8 * ry2 * off_x + 4 * ry2;
      end else begin
        kind = K_R1_POS;
        off_x++;
        if (off_y > 0) off_y--;
        dec4 += 8 * ry2 * off_x - 8 * rx2 * off_y + 4 * ry2;
      end
    end else begin
      if (!region_two) begin
        region_two = 1'b1;
        hx = 2 * off_x + 1;
        hy = off_y - 1;
        dec4 = ry2 * hx * hx + 4 * rx2 * hy * hy - 4 * rx2 * ry2;
      end
      if (off_y == 0) begin
        running = 1'b0;
        return 1'b0;
      end
      if (dec4 > 0) begin
        kind = K_R2_POS;
        off_y--;
        dec4 += 4 * rx2 - 8 * rx2 * off_y;
      end else begin
        kind = K_R2_NEG;
        off_x++;
        off_y--;
        dec4 += 4 * rx2 - 8 * rx2 * off_y + 8 * ry2 * off_x;
      end
    end
    px.last = (off_y == 0);
    if (px.last) running = 1'b0;
    px.right_col = 13'(orig_col + off_x);
    px.left_col  = 13'(orig_col - off_x);
    px.lower_row = 13'(orig_row + off_y);
    px.upper_row = 13'(orig_row - off_y);
    return 1'b1;
  endfunction

  task automatic offer(input bit cmd, input int rx, input int ry, input int cx, input int cy,
                       input row_check_t chk, input pixel_t typed);
    pixel_t     px;
    step_kind_t kind;
    bit         was_idle;
    bit         emits;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, 11'(cy), 11'(cx), 10'(ry), 10'(rx)};
    do @(posedge clk); while (!s_tready);
    was_idle = !running;
    emits = step_arc(cmd, rx, ry, cx, cy, px, kind);
    if (cmd == CMD_ADVANCE && was_idle) items_ignored++;
    else items_done++;
    if (cmd == CMD_START) ellipses_started++;
    if (emits) kind_seen[kind]++;
    case (chk)
      ROW_PRED:  if (emits) pending_pixels.push_back(px);
      ROW_POINT: pending_pixels.push_back(typed);
      default: ;
    endcase
  endtask

  task automatic advance_noise();
    offer(CMD_ADVANCE, $urandom_range(1023), $urandom_range(1023), $urandom_range(2047),
          $urandom_range(2047), ROW_PRED, '0);
  endtask

  task automatic draw_random_ellipse();
    int sel, rx, ry, cap, n, extra;
    sel = $urandom_range(99);
    cap = 1 << 30;
    if (sel < 8) begin
      rx = $urandom_range(1023);
      ry = $urandom_range(1023);
      cap = 40;
    end else if (sel < 14) begin
      rx = ($urandom_range(1) == 0) ? 0 : $urandom_range(12);
      ry = ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
    end else begin
      rx = $urandom_range(30, 1);
      ry = $urandom_range(30, 1);
    end
    if ($urandom_range(99) < 12) cap = $urandom_range(12, 1);
    offer(CMD_START, rx, ry, $urandom_range(2047), $urandom_range(2047), ROW_PRED, '0);
    n = 0;
    while (running && n < cap) begin
      advance_noise();
      n++;
    end
    extra = $urandom_range(2);
    repeat (extra) advance_noise();
  endtask

  // receiver
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[12:0], m_tdata[25:13], m_tdata[38:26], m_tdata[51:39], m_tlast};
      points_checked++;
      if (m_tlast) ellipses_closed++;
      if (pending_pixels.size() == 0) begin
        $error("point (%0d,%0d) with nothing expected", $signed(got.right_col),
               $signed(got.lower_row));
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.right_col !== want.right_col) begin
          $error("right_column: expected %0d, got %0d", $signed(want.right_col),
                 $signed(got.right_col));
          fail_count++;
        end
        if (got.left_col !== want.left_col) begin
          $error("left_column: expected %0d, got %0d", $signed(want.left_col),
                 $signed(got.left_col));
          fail_count++;
        end
        if (got.lower_row !== want.lower_row) begin
          $error("lower_row: expected %0d, got %0d", $signed(want.lower_row),
                 $signed(got.lower_row));
          fail_count++;
        end
        if (got.upper_row !== want.upper_row) begin
          $error("upper_row: expected %0d, got %0d", $signed(want.upper_row),
                 $signed(got.upper_row));
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last_point: expected %0d, got %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    pixel_t    typed;
    stim_row_t r;
    int        base;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= CMD_START;
    s_tdata  <= '0;
    hold_req = 1'b0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    fail_count = 0;
    items_done = 0;
    items_ignored = 0;
    points_checked = 0;
    ellipses_closed = 0;
    ellipses_started = 0;
    stall_cycles = 0;
    kind_seen = '{0, 0, 0, 0};
    semi_x = 0; semi_y = 0; orig_col = 0; orig_row = 0;
    off_x = 0; off_y = 0; dec4 = 0;
    region_two = 1'b0;
    running = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NDIR; i++) begin
      r = DIR_TAB[i];
      typed = {r.rc[12:0], r.lc[12:0], r.lr[12:0], r.ur[12:0], r.lst};
      offer(r.cmd, r.rx, r.ry, r.cx, r.cy, r.chk, typed);
    end
    base = items_done;

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 46 : 0;
      sink_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 10 : 0;
      if (ph == 2) hold_req = 1'b1;
      while (items_done < base + RAND_ITEMS * (ph + 1) / 3) draw_random_ellipse();
      // let every expected point come back before the next phase
      s_tvalid <= 1'b0;
      do @(posedge clk); while (pending_pixels.size() != 0);
    end

    repeat (30) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d expected points never arrived", pending_pixels.size());
      fail_count++;
    end
    $display("%0d items accepted (%0d advances while idle), %0d ellipses started, %0d closed",
             items_done + items_ignored, items_ignored, ellipses_started, ellipses_closed);
    $display("%0d points checked; region one -/+ %0d/%0d, region two +/- %0d/%0d",
             points_checked, kind_seen[K_R1_NEG], kind_seen[K_R1_POS],
             kind_seen[K_R2_POS], kind_seen[K_R2_NEG]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
